>>> sv/q16a_pkg.sv
`timescale 1ns / 1ps
package q16a_pkg;

    localparam int FracBits   = 16;
    localparam int Os256Bits  = 24;
    localparam int DivBits    = 56;
    localparam logic signed [63:0] RoundHalf = 64'sh8000;

    typedef enum logic [2:0] {
        CMD_MUL    = 3'd0,
        CMD_DIV    = 3'd1,
        CMD_DOT    = 3'd2,
        CMD_RDIV   = 3'd3,
        CMD_DIV256 = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
        logic signed [31:0] operand_d;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               divide_by_zero;
    } rsp_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] num;
        logic signed [31:0] b;
    } prod_t;

    typedef struct packed {
        logic [31:0]        rem;
        logic [DivBits-1:0] num;
        logic [31:0]        dvs;
        logic               neg;
        logic               is_div;
        logic               dz;
        logic [31:0]        res;
    } cell_t;

endpackage

>>> sv/q16a_mul_stage.sv
`timescale 1ns / 1ps
module q16a_mul_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  q16a_pkg::req_t up,
    output logic           dn_valid,
    input  logic           dn_ready,
    output q16a_pkg::prod_t dn
);
    import q16a_pkg::*;

    logic  v_reg;
    req_t  item_reg;
    logic signed [63:0] a64;
    logic signed [63:0] half;
    logic signed [63:0] shifted;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up;
        end
    end

    always_comb
    begin
        a64  = 64'(item_reg.operand_a);
        half = 64'(item_reg.operand_b >>> 1);
        if (item_reg.command == CMD_DIV256)
        begin
            shifted = a64 <<< Os256Bits;
        end
        else
        begin
            shifted = a64 <<< FracBits;
        end
        dn.command = item_reg.command;
        dn.b       = item_reg.operand_b;
        dn.p2      = 64'(item_reg.operand_b) * 64'(item_reg.operand_d);
        if (item_reg.command == CMD_DOT)
        begin
            dn.p1 = a64 * 64'(item_reg.operand_c);
        end
        else
        begin
            dn.p1 = a64 * 64'(item_reg.operand_b);
        end
        if (item_reg.command == CMD_RDIV)
        begin
            dn.num = item_reg.operand_a[31] ? (shifted - half) : (shifted + half);
        end
        else
        begin
            dn.num = shifted;
        end
    end

endmodule

>>> sv/q16a_setup_stage.sv
`timescale 1ns / 1ps
module q16a_setup_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  q16a_pkg::prod_t up,
    output logic            dn_valid,
    input  logic            dn_ready,
    output q16a_pkg::cell_t dn
);
    import q16a_pkg::*;

    logic  v_reg;
    prod_t item_reg;
    logic signed [63:0] sum;
    logic [63:0] num_mag;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up;
        end
    end

    always_comb
    begin
        case (item_reg.command)
            CMD_MUL: sum = item_reg.p1 + RoundHalf;
            CMD_DOT: sum = item_reg.p1 + item_reg.p2;
            default: sum = '0;
        endcase
        num_mag   = item_reg.num[63] ? 64'(-item_reg.num) : 64'(item_reg.num);
        dn.rem    = '0;
        dn.num    = num_mag[DivBits-1:0];
        dn.dvs    = item_reg.b[31] ? 32'(-item_reg.b) : 32'(item_reg.b);
        dn.neg    = item_reg.num[63] ^ item_reg.b[31];
        dn.is_div = (item_reg.command inside {CMD_DIV, CMD_RDIV, CMD_DIV256});
        dn.dz     = dn.is_div && (item_reg.b == '0);
        dn.res    = 32'(sum[63:FracBits]);
    end

endmodule

>>> sv/q16a_div_cell.sv
`timescale 1ns / 1ps
module q16a_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  q16a_pkg::cell_t up,
    output logic            dn_valid,
    input  logic            dn_ready,
    output q16a_pkg::cell_t dn
);
    import q16a_pkg::*;

    logic  v_reg;
    cell_t item_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up;
        end
    end

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial = {item_reg.rem, item_reg.num[DivBits-1]};
        diff  = {1'b0, trial} - {2'b00, item_reg.dvs};
        dn    = item_reg;
        if (!diff[33])
        begin
            dn.rem = diff[31:0];
            dn.num = {item_reg.num[DivBits-2:0], 1'b1};
        end
        else
        begin
            dn.rem = trial[31:0];
            dn.num = {item_reg.num[DivBits-2:0], 1'b0};
        end
    end

endmodule

>>> sv/q16a_out_stage.sv
`timescale 1ns / 1ps
module q16a_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  q16a_pkg::cell_t up,
    output logic            dn_valid,
    input  logic            dn_ready,
    output q16a_pkg::rsp_t  dn
);
    import q16a_pkg::*;

    logic  v_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic [31:0] quot;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn       = rsp_reg;

    always_comb
    begin
        quot = up.neg ? -up.num[31:0] : up.num[31:0];
        rsp_next.divide_by_zero = up.dz;
        if (up.dz)
        begin
            rsp_next.result_value = '0;
        end
        else if (up.is_div)
        begin
            rsp_next.result_value = quot;
        end
        else
        begin
            rsp_next.result_value = up.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

>>> sv/q16_fixed_point_alu_top.sv
`timescale 1ns / 1ps
// Every command takes the same path from request transfer to response valid:
// the request register, setup, 56 divider cells and the output register.
// Throughput: one item per cycle; a stage holds only while it is full and its
// successor cannot take the transfer.
// Reset clears every stage's valid bit; payload registers are not reset.
module q16_fixed_point_alu_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  q16a_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output q16a_pkg::rsp_t  rsp
);
    import q16a_pkg::*;

    logic  prod_valid;
    logic  prod_ready;
    prod_t prod;

    logic  cv [DivBits+1];
    logic  cr [DivBits+1];
    cell_t cd [DivBits+1];

    q16a_mul_stage u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up       (req),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn       (prod)
    );

    q16a_setup_stage u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up       (prod),
        .dn_valid (cv[0]),
        .dn_ready (cr[0]),
        .dn       (cd[0])
    );

    for (genvar i = 0; i < DivBits; i++)
    begin : g_cell
        q16a_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cv[i]),
            .up_ready (cr[i]),
            .up       (cd[i]),
            .dn_valid (cv[i+1]),
            .dn_ready (cr[i+1]),
            .dn       (cd[i+1])
        );
    end

    q16a_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cv[DivBits]),
        .up_ready (cr[DivBits]),
        .up       (cd[DivBits]),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn       (rsp)
    );

endmodule

>>> verif/tb_q16_fixed_point_alu_top.sv
`timescale 1ns / 1ps
module tb_q16_fixed_point_alu_top;
    import q16a_pkg::*;

    class q16_scoreboard;
        rsp_t expected_q[$];
        int   mismatches = 0;

        function rsp_t compute(req_t r);
            rsp_t        o;
            longint      a;
            longint      b;
            longint      c;
            longint      d;
            longint      half;
            longint      num;
            longint      quo;
            logic [63:0] acc;
            a = r.operand_a;
            b = r.operand_b;
            c = r.operand_c;
            d = r.operand_d;
            o.result_value = '0;
            o.divide_by_zero = 1'b0;
            case (r.command)
                CMD_MUL:
                begin
                    acc = a * b + RoundHalf;
                    o.result_value = acc[47:16];
                end
                CMD_DOT:
                begin
                    acc = a * c + b * d;
                    o.result_value = acc[47:16];
                end
                CMD_DIV, CMD_RDIV, CMD_DIV256:
                begin
                    if (b == 0)
                    begin
                        o.divide_by_zero = 1'b1;
                    end
                    else
                    begin
                        num = a <<< ((r.command == CMD_DIV256) ? Os256Bits : FracBits);
                        if (r.command == CMD_RDIV)
                        begin
                            half = b >>> 1;
                            num = (a < 0) ? num - half : num + half;
                        end
                        quo = num / b;
                        o.result_value = quo[31:0];
                    end
                end
                default:
                begin
                end
            endcase
            return o;
        endfunction

        function void note(req_t r);
            expected_q.push_back(compute(r));
        endfunction

        function void check(rsp_t got);
            rsp_t exp_rsp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h / %b", got.result_value,
                             got.divide_by_zero);
                return;
            end
            exp_rsp = expected_q.pop_front();
            if (got.result_value !== exp_rsp.result_value ||
                got.divide_by_zero !== exp_rsp.divide_by_zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h / %b, got %h / %b",
                             exp_rsp.result_value, exp_rsp.divide_by_zero,
                             got.result_value, got.divide_by_zero);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    q16_scoreboard sb = new();
    bit calm = 1'b0;
    bit long_hold = 1'b0;

    q16_fixed_point_alu_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            sb.note(req);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check(rsp);
    end

    // Receiver: random back-pressure bursts, plus one long hold on request.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send_op(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
        req_t r;
        r.command = cmd;
        r.operand_a = a;
        r.operand_b = b;
        r.operand_c = c;
        r.operand_d = d;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 64)) - 32);
            3: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [2:0]  cmd;
        logic [31:0] b;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: extremes, zero divisors, negative rdiv divisor, unused codes.
        send_op(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_op(CMD_MUL, 32'h0000_8000, 32'h0000_0001, 0, 0);
        send_op(CMD_MUL, 32'hffff_ffff, 32'h0000_8000, 0, 0);
        send_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0);
        send_op(CMD_DIV, 32'h7fff_ffff, 32'h0000_0001, 0, 0);
        send_op(CMD_DIV, 32'h1234_5678, 32'h0000_0000, 0, 0);
        send_op(CMD_DIV, 32'hffff_0000, 32'h0003_0000, 0, 0);
        send_op(CMD_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(CMD_DOT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(CMD_DOT, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
        send_op(CMD_RDIV, 32'h8000_0000, 32'hffff_ffff, 0, 0);
        send_op(CMD_RDIV, 32'hffff_0000, 32'hfffd_0000, 0, 0);
        send_op(CMD_RDIV, 32'h0001_0000, 32'h8000_0000, 0, 0);
        send_op(CMD_RDIV, 32'h0000_0005, 32'h0000_0000, 0, 0);
        send_op(CMD_RDIV, 32'h7fff_ffff, 32'h0000_0003, 0, 0);
        send_op(CMD_DIV256, 32'h8000_0000, 32'h0000_0001, 0, 0);
        send_op(CMD_DIV256, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
        send_op(CMD_DIV256, 32'h0000_0001, 32'h0000_0000, 0, 0);
        send_op(3'd5, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
        send_op(3'd6, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
        send_op(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1);

        for (int i = 0; i < 1150; i++)
        begin
            if (i == 300)
                long_hold = 1'b1;
            if (i == 600)
            begin
                // Hold off until the pipeline has drained completely.
                req_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i == 1000)
                calm = 1'b1;
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            b = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
            send_op(cmd, pick_operand(), b, pick_operand(), pick_operand());
            if (!calm && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 18));
        end
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> q16_fixed_point_alu_top.f
sv/q16a_pkg.sv
sv/q16a_mul_stage.sv
sv/q16a_setup_stage.sv
sv/q16a_div_cell.sv
sv/q16a_out_stage.sv
sv/q16_fixed_point_alu_top.sv
verif/tb_q16_fixed_point_alu_top.sv
